/* rtl/assert_macros.svh */
// Assertion macros shared by the recovery unit's RTL files.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on a named clock, ignored while the named reset is high
`define RPDR_ASSERT_CLK(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on the local clk, ignored while rst is high
`define RPDR_ASSERT(label, prop, msg) \
  `RPDR_ASSERT_CLK(label, clk, rst, prop, msg)

`endif

/* rtl/rpdr_pkg.sv */
// Types, codes and fixed widths of the rotating parity disk recovery unit.
// No dependencies; imported by the interfaces, controller, datapath and top level.
package rpdr_pkg;

  // Field widths of the item, result and configuration channels
  localparam int MAX_DISKS  = 6;
  localparam int MIN_DISKS  = 2;
  localparam int ACT_W      = 2;
  localparam int COL_W      = MAX_DISKS;
  localparam int NIB_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Configuration register widths, limits and reset values
  localparam int DC_W            = 3;
  localparam int BB_W            = 7;
  localparam int BC_W            = 8;
  localparam int MAX_BLOCK_BITS  = 64;
  localparam int MAX_BLOCK_COUNT = 128;
  localparam int DC_RESET        = 3;
  localparam int BB_RESET        = 4;
  localparam int BC_RESET        = 1;

  // Cursor and address arithmetic widths
  localparam int CUR_BIT_W  = 7;   // holds block_bits itself before wrapping
  localparam int CUR_DISK_W = 3;
  localparam int CUR_BLK_W  = 8;   // holds block_count itself when done
  localparam int TAKEN_W    = 3;
  localparam int PROD_W     = 15;  // block index times block bits, plus bit
  localparam int SUM_W      = 13;  // a column index before reduction is below 8192
  localparam int TOTAL_W    = 14;  // block_bits times block_count, up to 8192

  typedef enum logic [ACT_W-1:0] {
    ACT_START = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_FETCH = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISK_COUNT  = 2'd0,
    REG_BLOCK_BITS  = 2'd1,
    REG_BLOCK_COUNT = 2'd2,
    REG_ODD_PARITY  = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PAR,
    ST_NORM,
    ST_ADDR,
    ST_READ,
    ST_TAKE,
    ST_FIN
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic exec_start;
    logic exec_load;
    logic par_init;
    logic par_step;
    logic norm_step;
    logic addr_calc;
    logic rd_en;
    logic take;
    logic out_load;
  } rpdr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    action_t act;
    logic    fetch_ok;
    logic    par_stale;
    logic    par_last;
    logic    norm_stable;
    logic    cur_done;
    logic    taken_full;
  } rpdr_status_t;

endpackage

/* rtl/rpdr_if.sv */
// Valid/ready channel interfaces: input items, result items and register writes.
// Depends on rpdr_pkg for field widths.
interface rpdr_in_if import rpdr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [COL_W-1:0] column_bits;
  logic [COL_W-1:0] erased_mask;

  modport source(output valid, action, column_bits, erased_mask, input ready);
  modport sink(input valid, action, column_bits, erased_mask, output ready);
endinterface

interface rpdr_out_if import rpdr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             set_valid;
  logic [NIB_W-1:0] nibble;
  logic             nibble_valid;
  logic             last_nibble;

  modport source(output valid, set_valid, nibble, nibble_valid, last_nibble, input ready);
  modport sink(input valid, set_valid, nibble, nibble_valid, last_nibble, output ready);
endinterface

interface rpdr_cfg_if import rpdr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* rtl/rpdr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the repaired column store.
module rpdr_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 8192,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/rpdr_ctrl.sv */
// Controller of the recovery unit: item handshake, sequencing and result slot.
// Depends on rpdr_pkg for state, command and status types.
`include "assert_macros.svh"

module rpdr_ctrl import rpdr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_ready,
  output logic         result_valid,
  input  logic         result_ready,
  output rpdr_cmd_t    cmd,
  input  rpdr_status_t st
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result slot: fill on load, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  assign item_ready = (state == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (st.act)
          ACT_START: begin
            cmd.exec_start = 1'b1;
            state_next     = ST_FIN;
          end
          ACT_LOAD: begin
            cmd.exec_load = 1'b1;
            state_next    = ST_FIN;
          end
          ACT_FETCH: begin
            if (!st.fetch_ok) begin
              state_next = ST_FIN;
            end else if (st.par_stale) begin
              cmd.par_init = 1'b1;
              state_next   = ST_PAR;
            end else begin
              state_next = ST_NORM;
            end
          end
          default: begin
            state_next = ST_FIN;
          end
        endcase
      end
      ST_PAR: begin
        cmd.par_step = 1'b1;
        if (st.par_last) begin
          state_next = ST_NORM;
        end
      end
      ST_NORM: begin
        if (!st.norm_stable) begin
          cmd.norm_step = 1'b1;
        end else if (st.cur_done || st.taken_full) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd.addr_calc = 1'b1;
        state_next    = ST_READ;
      end
      ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_TAKE;
      end
      ST_TAKE: begin
        cmd.take   = 1'b1;
        state_next = ST_NORM;
      end
      ST_FIN: begin
        if (!result_valid || result_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // A finished item always reaches the result slot
  `RPDR_ASSERT(a_fin_loads_result, (state == ST_FIN) && (!result_valid || result_ready) |=> result_valid, "finished item did not reach the result slot")

  // A read is always followed by taking its bit
  `RPDR_ASSERT(a_read_then_take, cmd.rd_en |=> (state == ST_TAKE), "store read not followed by bit take")

endmodule

/* rtl/rpdr_dp.sv */
// Datapath of the recovery unit: registers, column repair, store, fetch cursor.
// Depends on rpdr_pkg and rpdr_ram; driven by rpdr_ctrl commands.
`include "assert_macros.svh"

module rpdr_dp import rpdr_pkg::*; #(
  parameter int MAX_COLUMNS = 8192
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [ACT_W-1:0]      action,
  input  logic [COL_W-1:0]      column_bits,
  input  logic [COL_W-1:0]      erased_mask,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  rpdr_cmd_t             cmd,
  output rpdr_status_t          st,
  output logic                  set_valid,
  output logic [NIB_W-1:0]      nibble,
  output logic                  nibble_valid,
  output logic                  last_nibble
);

  localparam int AW        = $clog2(MAX_COLUMNS);
  localparam int CLW       = $clog2(MAX_COLUMNS + 1);
  localparam int TW        = (CLW > TOTAL_W) ? CLW : TOTAL_W;
  // The store holds at least 64 columns, so seven reduction steps cover 13 bits
  localparam int MOD_STEPS = SUM_W - $clog2(64);
  localparam int RW        = AW + MOD_STEPS + 1;

  // Reduce a column index modulo the store depth by restoring subtraction
  function automatic logic [RW-1:0] col_reduce(input logic [SUM_W-1:0] x);
    logic [RW-1:0] r;
    r = RW'(x);
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      if (r >= (RW'(MAX_COLUMNS) << k)) begin
        r = r - (RW'(MAX_COLUMNS) << k);
      end
    end
    return r;
  endfunction

  // Configuration registers
  logic [DC_W-1:0] disk_count;
  logic [BB_W-1:0] block_bits;
  logic [BC_W-1:0] block_count;
  logic            odd_parity;

  // Latched item
  action_t          act;
  logic [COL_W-1:0] bits;
  logic [COL_W-1:0] erased;

  // Set state
  logic [CLW-1:0] loaded;
  logic           set_invalid;

  // Fetch cursor, rotating parity disk and its resync
  logic [CUR_BLK_W-1:0]  cur_block, blk_next;
  logic [CUR_DISK_W-1:0] cur_disk, disk_next;
  logic [CUR_BIT_W-1:0]  cur_bit, bit_next;
  logic [DC_W-1:0]       par_disk, par_next;
  logic                  par_stale;
  logic [2:0]            par_cnt;
  logic [DC_W-1:0]       par_rem;
  logic [DC_W:0]         rem_shift, rem_red;

  // Nibble assembly and store access
  logic [NIB_W-1:0]   nib;
  logic [TAKEN_W-1:0] taken;
  logic [SUM_W-1:0]   sum_reg;
  logic [PROD_W-1:0]  sum_full;
  logic [RW-1:0]      rd_full;
  logic [AW-1:0]      raddr;
  logic [COL_W-1:0]   rdata;
  logic               ram_we;

  // Effective register values and column total
  logic [DC_W-1:0]    n_eff;
  logic [BB_W-1:0]    bb_eff;
  logic [BC_W-1:0]    bc_eff;
  logic [PROD_W-1:0]  prod;
  logic [TW-1:0]      total;
  logic               can_load;
  logic               blk_lt;
  logic               norm_stable;

  // Column repair
  logic [COL_W:0]   dmask_w;
  logic [COL_W-1:0] dmask, er, good, good_fixed;
  logic             col_par, col_break;
  logic [2:0]       ecount;

  // Saturate the registers into their legal ranges
  always_comb begin
    if (disk_count < DC_W'(MIN_DISKS)) begin
      n_eff = DC_W'(MIN_DISKS);
    end else if (disk_count > DC_W'(MAX_DISKS)) begin
      n_eff = DC_W'(MAX_DISKS);
    end else begin
      n_eff = disk_count;
    end
    if (block_bits == '0) begin
      bb_eff = BB_W'(1);
    end else if (block_bits > BB_W'(MAX_BLOCK_BITS)) begin
      bb_eff = BB_W'(MAX_BLOCK_BITS);
    end else begin
      bb_eff = block_bits;
    end
    if (block_count == '0) begin
      bc_eff = BC_W'(1);
    end else if (block_count > BC_W'(MAX_BLOCK_COUNT)) begin
      bc_eff = BC_W'(MAX_BLOCK_COUNT);
    end else begin
      bc_eff = block_count;
    end
  end

  // Column total, capped at the store depth
  assign prod     = PROD_W'(bb_eff) * PROD_W'(bc_eff);
  assign total    = (TW'(prod) > TW'(MAX_COLUMNS)) ? TW'(MAX_COLUMNS) : TW'(prod);
  assign can_load = TW'(loaded) < total;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      disk_count  <= DC_W'(DC_RESET);
      block_bits  <= BB_W'(BB_RESET);
      block_count <= BC_W'(BC_RESET);
      odd_parity  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_DISK_COUNT:  disk_count  <= cfg_data[DC_W-1:0];
        REG_BLOCK_BITS:  block_bits  <= cfg_data[BB_W-1:0];
        REG_BLOCK_COUNT: block_count <= cfg_data[BC_W-1:0];
        REG_ODD_PARITY:  odd_parity  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act    <= action_t'(action);
      bits   <= column_bits;
      erased <= erased_mask;
    end
  end

  // Repair one column: rebuild a single erased bit, flag bad columns
  always_comb begin
    dmask_w    = (COL_W + 1)'((COL_W + 1)'(1) << n_eff) - (COL_W + 1)'(1);
    dmask      = dmask_w[COL_W-1:0];
    er         = erased & dmask;
    good       = bits & dmask & ~er;
    ecount     = 3'($countones(er));
    col_par    = ^good;
    col_break  = (ecount > 3'd1) || ((ecount == 3'd0) && (col_par != odd_parity));
    good_fixed = ((ecount == 3'd1) && (col_par != odd_parity)) ? (good | er) : good;
  end

  assign ram_we = cmd.exec_load && can_load;

  // Set state: column count and validity
  always_ff @(posedge clk) begin
    if (rst || cmd.exec_start) begin
      loaded      <= '0;
      set_invalid <= 1'b0;
    end else if (ram_we) begin
      loaded      <= loaded + CLW'(1);
      set_invalid <= set_invalid | col_break;
    end
  end

  // One cursor step towards the next data bit
  always_comb begin
    blk_lt      = cur_block < bc_eff;
    blk_next    = cur_block;
    disk_next   = cur_disk;
    bit_next    = cur_bit;
    par_next    = par_disk;
    norm_stable = 1'b0;
    if (!blk_lt) begin
      norm_stable = 1'b1;
    end else if (cur_bit >= bb_eff) begin
      bit_next  = '0;
      disk_next = cur_disk + CUR_DISK_W'(1);
    end else if (cur_disk >= n_eff) begin
      disk_next = '0;
      bit_next  = '0;
      blk_next  = cur_block + CUR_BLK_W'(1);
      par_next  = (DC_W'(par_disk + DC_W'(1)) == n_eff) ? '0 : DC_W'(par_disk + DC_W'(1));
    end else if (cur_disk == par_disk) begin
      disk_next = cur_disk + CUR_DISK_W'(1);
      bit_next  = '0;
    end else begin
      norm_stable = 1'b1;
    end
  end

  // Parity disk resync: block index modulo disk count, one bit per cycle
  assign rem_shift = {par_rem, cur_block[par_cnt]};
  assign rem_red   = (rem_shift >= {1'b0, n_eff}) ? (rem_shift - {1'b0, n_eff}) : rem_shift;

  always_ff @(posedge clk) begin
    if (cmd.par_init) begin
      par_cnt <= 3'(CUR_BLK_W - 1);
      par_rem <= '0;
    end else if (cmd.par_step) begin
      par_cnt <= par_cnt - 3'd1;
      par_rem <= rem_red[DC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.exec_start) begin
      par_stale <= 1'b0;
    end else if (cfg_write && (cfg_reg_t'(cfg_index) == REG_DISK_COUNT)) begin
      par_stale <= 1'b1;
    end else if (cmd.par_step && (par_cnt == 3'd0)) begin
      par_stale <= 1'b0;
    end
  end

  // Cursor registers
  always_ff @(posedge clk) begin
    if (rst || cmd.exec_start) begin
      cur_block <= '0;
      cur_disk  <= '0;
      cur_bit   <= '0;
      par_disk  <= '0;
    end else if (cmd.norm_step) begin
      cur_block <= blk_next;
      cur_disk  <= disk_next;
      cur_bit   <= bit_next;
      par_disk  <= par_next;
    end else if (cmd.take) begin
      cur_bit <= cur_bit + CUR_BIT_W'(1);
    end else if (cmd.par_step && (par_cnt == 3'd0)) begin
      par_disk <= rem_red[DC_W-1:0];
    end
  end

  // Column address of the cursor bit
  assign sum_full = PROD_W'(cur_block) * PROD_W'(bb_eff) + PROD_W'(cur_bit);

  always_ff @(posedge clk) begin
    if (cmd.addr_calc) begin
      sum_reg <= sum_full[SUM_W-1:0];
    end
  end

  assign rd_full = col_reduce(sum_reg);
  assign raddr   = AW'(rd_full);

  rpdr_ram #(
    .WIDTH (COL_W),
    .DEPTH (MAX_COLUMNS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (loaded[AW-1:0]),
    .wdata (good_fixed),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Assemble the nibble, first bit in the top position
  always_ff @(posedge clk) begin
    if (rst || cmd.accept) begin
      nib   <= '0;
      taken <= '0;
    end else if (cmd.take) begin
      nib   <= nib | (NIB_W'(rdata[cur_disk]) << (2'd3 - taken[1:0]));
      taken <= taken + TAKEN_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      set_valid    <= !set_invalid;
      nibble       <= nib;
      nibble_valid <= (taken != '0);
      last_nibble  <= (taken != '0) && !blk_lt;
    end
  end

  // Status to the controller
  always_comb begin
    st.act         = act;
    st.fetch_ok    = !set_invalid && !can_load;
    st.par_stale   = par_stale;
    st.par_last    = (par_cnt == 3'd0);
    st.norm_stable = norm_stable;
    st.cur_done    = !blk_lt;
    st.taken_full  = (taken == TAKEN_W'(NIB_W));
  end

  `RPDR_ASSERT(a_taken_range, taken <= TAKEN_W'(NIB_W), "more than four bits gathered for a nibble")
  `RPDR_ASSERT(a_load_counts, ram_we |=> (loaded == $past(loaded) + CLW'(1)), "stored column not counted")
  `RPDR_ASSERT(a_par_in_range, !par_stale |-> (par_disk < n_eff), "parity disk beyond disk count")
  `RPDR_ASSERT(a_raddr_in_range, cmd.rd_en |-> (rd_full < RW'(MAX_COLUMNS)), "column address beyond store depth")

endmodule

/* rtl/rotating_parity_disk_recovery_unit.sv */
// Rotating parity disk recovery unit. Start, load, unknown and refused fetch items pass
// through ST_EXEC and ST_FIN to the result; one item is worked on at a time, the next
// accepted while the result waits. A fetch on a valid, fully loaded set reads up to four
// bits, each via ST_NORM, ST_ADDR, ST_READ, ST_TAKE, with ST_NORM steps for cursor skips
// (parity disk, disk or block wrap). The first such fetch after a disk_count write, unless
// a start intervenes, resyncs the parity disk. Synchronous reset restores defaults.
module rotating_parity_disk_recovery_unit import rpdr_pkg::*; #(
  parameter int MAX_COLUMNS = 8192
) (
  input logic       clk,
  input logic       rst,
  rpdr_in_if.sink   item,
  rpdr_out_if.source result,
  rpdr_cfg_if.sink  cfg
);

  rpdr_cmd_t    cmd;
  rpdr_status_t st;

  // Registers take a write in any cycle
  assign cfg.ready = 1'b1;

  rpdr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .cmd          (cmd),
    .st           (st)
  );

  rpdr_dp #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .action       (item.action),
    .column_bits  (item.column_bits),
    .erased_mask  (item.erased_mask),
    .cfg_write    (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .cmd          (cmd),
    .st           (st),
    .set_valid    (result.set_valid),
    .nibble       (result.nibble),
    .nibble_valid (result.nibble_valid),
    .last_nibble  (result.last_nibble)
  );

endmodule
